/* hw/rtl/segx_pkg.sv */
// Shared types and constants for the 2D segment intersection unit.
package segx_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int FRACTION_BITS = 12;
    localparam int DELTA_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH    = 2 * DELTA_WIDTH;
    localparam int CROSS_WIDTH   = PROD_WIDTH + 1;
    localparam int MAG_WIDTH     = CROSS_WIDTH - 1;
    localparam int THR_WIDTH     = 40;
    localparam int PARAM_FRAC    = 24;
    // signed line parameter, magnitude saturates at one plus one lsb
    localparam int PARAM_WIDTH   = PARAM_FRAC + 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_WIDTH    = 2;
    localparam int QCNT_WIDTH    = 3;

    localparam logic [THR_WIDTH-1:0] THRESH_RESET =
        THR_WIDTH'((64'd1 << (2 * FRACTION_BITS)) / 1000);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DELTA_WIDTH-1:0] t_delta;
    typedef logic [MAG_WIDTH-1:0]          t_mag;
    typedef logic signed [PARAM_WIDTH-1:0] t_param;

    localparam t_param PARAM_ONE = t_param'(1) <<< PARAM_FRAC;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_POINT   = 2'd1,
        KIND_SEGMENT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_DONE    = 2'd0,
        MODE_CROSS   = 2'd1,
        MODE_OVERLAP = 2'd2
    } t_mode;

    // travels beside the divider
    typedef struct packed {
        t_mode  mode;
        t_kind  kind;
        t_coord base_x;
        t_coord base_y;
        t_delta delta_x;
        t_delta delta_y;
    } t_side;

    typedef struct packed {
        t_side side;
        t_mag  num0;
        t_mag  num1;
        t_mag  den;
        logic  neg0;
        logic  neg1;
        logic  sat0;
        logic  sat1;
    } t_job;

endpackage

/* hw/rtl/segx_div.sv */
// Pipelined fraction divider lane: one quotient bit per stage.
module segx_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  segx_pkg::t_mag   i_num,
    input  segx_pkg::t_mag   i_den,
    input  logic             i_neg,
    input  logic             i_sat,
    output segx_pkg::t_param o_quot
);

    segx_pkg::t_mag                   r_rem  [segx_pkg::PARAM_FRAC];
    segx_pkg::t_mag                   r_den  [segx_pkg::PARAM_FRAC];
    logic [segx_pkg::PARAM_FRAC:0]    r_quot [segx_pkg::PARAM_FRAC];
    logic                             r_neg  [segx_pkg::PARAM_FRAC];
    logic                             r_sat  [segx_pkg::PARAM_FRAC];

    segx_pkg::t_mag                   w_rem_in  [segx_pkg::PARAM_FRAC];
    segx_pkg::t_mag                   w_den_in  [segx_pkg::PARAM_FRAC];
    logic [segx_pkg::PARAM_FRAC:0]    w_quot_in [segx_pkg::PARAM_FRAC];
    logic                             w_neg_in  [segx_pkg::PARAM_FRAC];
    logic                             w_sat_in  [segx_pkg::PARAM_FRAC];
    segx_pkg::t_mag                   w_rem_nx  [segx_pkg::PARAM_FRAC];
    logic [segx_pkg::PARAM_FRAC:0]    w_quot_nx [segx_pkg::PARAM_FRAC];

    logic                             w_int;
    logic [segx_pkg::PARAM_FRAC:0]    w_mag;

    // numerator exceeds the divisor only when the saturate flag overrides the result, so the integer bit is n == d
    assign w_int = (i_num == i_den);

    always_comb begin
        logic [segx_pkg::MAG_WIDTH:0] shift;
        logic                         ge;
        w_rem_in[0]  = w_int ? '0 : i_num;
        w_den_in[0]  = i_den;
        w_quot_in[0] = (segx_pkg::PARAM_FRAC + 1)'(w_int);
        w_neg_in[0]  = i_neg;
        w_sat_in[0]  = i_sat;
        for (int k = 1; k < segx_pkg::PARAM_FRAC; k++) begin
            w_rem_in[k]  = r_rem[k-1];
            w_den_in[k]  = r_den[k-1];
            w_quot_in[k] = r_quot[k-1];
            w_neg_in[k]  = r_neg[k-1];
            w_sat_in[k]  = r_sat[k-1];
        end
        for (int k = 0; k < segx_pkg::PARAM_FRAC; k++) begin
            shift = {w_rem_in[k], 1'b0};
            ge    = (shift >= {1'b0, w_den_in[k]});
            w_rem_nx[k]  = ge ? segx_pkg::MAG_WIDTH'(shift - {1'b0, w_den_in[k]})
                              : shift[segx_pkg::MAG_WIDTH-1:0];
            w_quot_nx[k] = {w_quot_in[k][segx_pkg::PARAM_FRAC-1:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < segx_pkg::PARAM_FRAC; k++) begin
                r_rem[k]  <= w_rem_nx[k];
                r_den[k]  <= w_den_in[k];
                r_quot[k] <= w_quot_nx[k];
                r_neg[k]  <= w_neg_in[k];
                r_sat[k]  <= w_sat_in[k];
            end
        end
    end

    // saturated magnitude is one plus one lsb: still outside [0,1]
    assign w_mag = r_sat[segx_pkg::PARAM_FRAC-1]
                 ? (segx_pkg::PARAM_FRAC + 1)'(segx_pkg::PARAM_ONE + 1)
                 : r_quot[segx_pkg::PARAM_FRAC-1];

    assign o_quot = r_neg[segx_pkg::PARAM_FRAC-1]
                  ? -segx_pkg::t_param'(w_mag)
                  : segx_pkg::t_param'(w_mag);

endmodule

/* hw/rtl/segx_front.sv */
// Front end: cross products and case classification into divider jobs.
module segx_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  segx_pkg::t_coord                i_a_start_x,
    input  segx_pkg::t_coord                i_a_start_y,
    input  segx_pkg::t_coord                i_a_end_x,
    input  segx_pkg::t_coord                i_a_end_y,
    input  segx_pkg::t_coord                i_b_start_x,
    input  segx_pkg::t_coord                i_b_start_y,
    input  segx_pkg::t_coord                i_b_end_x,
    input  segx_pkg::t_coord                i_b_end_y,
    input  logic [segx_pkg::THR_WIDTH-1:0]  i_thr,
    input  logic                            i_full,
    output logic                            o_push,
    output segx_pkg::t_job                  o_job
);

    typedef struct packed {
        segx_pkg::t_coord ax;
        segx_pkg::t_coord ay;
        segx_pkg::t_coord aex;
        segx_pkg::t_coord aey;
        segx_pkg::t_coord bx;
        segx_pkg::t_coord by;
        segx_pkg::t_coord bex;
        segx_pkg::t_coord bey;
    } t_seg;

    typedef logic signed [segx_pkg::PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [segx_pkg::CROSS_WIDTH-1:0] t_cross;

    function automatic segx_pkg::t_mag delta_mag(input segx_pkg::t_delta v);
        logic [segx_pkg::DELTA_WIDTH:0] ext;
        ext = {v[segx_pkg::DELTA_WIDTH-1], v};
        if (v[segx_pkg::DELTA_WIDTH-1]) ext = -ext;
        return segx_pkg::t_mag'(ext);
    endfunction

    function automatic logic in_range(input segx_pkg::t_coord p,
                                      input segx_pkg::t_coord s,
                                      input segx_pkg::t_coord e);
        return (s <= p && p <= e) || (s >= p && p >= e);
    endfunction

    logic   w_en;
    logic   r_s1_valid, r_s2_valid, r_s3_valid;
    t_seg   r_s1, r_s2, r_s3;
    t_prod  r_s2_uxvy, r_s2_uyvx, r_s2_uxwy, r_s2_uywx, r_s2_vxwy, r_s2_vywx;
    t_cross r_s3_d, r_s3_nt, r_s3_ns;

    segx_pkg::t_delta w1_ux, w1_uy, w1_vx, w1_vy, w1_wx, w1_wy;
    segx_pkg::t_delta w_ux, w_uy, w_vx, w_vy, w_wx, w_wy, w_ex, w_ey;
    segx_pkg::t_delta w_n0, w_n1, w_dn;
    segx_pkg::t_mag   w_d_mag, w_ns_mag, w_nt_mag, w_n0_mag, w_n1_mag, w_dn_mag;
    logic             w_d_neg, w_par, w_out_s, w_out_t, w_upt, w_vpt, w_on_a, w_on_b;

    assign w_en    = !(r_s3_valid && i_full);
    assign o_stall = !w_en;
    assign o_push  = r_s3_valid && !i_full;

    // stage 1 deltas
    assign w1_ux = segx_pkg::t_delta'(r_s1.aex) - segx_pkg::t_delta'(r_s1.ax);
    assign w1_uy = segx_pkg::t_delta'(r_s1.aey) - segx_pkg::t_delta'(r_s1.ay);
    assign w1_vx = segx_pkg::t_delta'(r_s1.bex) - segx_pkg::t_delta'(r_s1.bx);
    assign w1_vy = segx_pkg::t_delta'(r_s1.bey) - segx_pkg::t_delta'(r_s1.by);
    assign w1_wx = segx_pkg::t_delta'(r_s1.ax)  - segx_pkg::t_delta'(r_s1.bx);
    assign w1_wy = segx_pkg::t_delta'(r_s1.ay)  - segx_pkg::t_delta'(r_s1.by);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1      <= '{i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
                           i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y};
            r_s2      <= r_s1;
            r_s2_uxvy <= w1_ux * w1_vy;
            r_s2_uyvx <= w1_uy * w1_vx;
            r_s2_uxwy <= w1_ux * w1_wy;
            r_s2_uywx <= w1_uy * w1_wx;
            r_s2_vxwy <= w1_vx * w1_wy;
            r_s2_vywx <= w1_vy * w1_wx;
            r_s3      <= r_s2;
            r_s3_d    <= t_cross'(r_s2_uxvy) - t_cross'(r_s2_uyvx);
            r_s3_nt   <= t_cross'(r_s2_uxwy) - t_cross'(r_s2_uywx);
            r_s3_ns   <= t_cross'(r_s2_vxwy) - t_cross'(r_s2_vywx);
        end
    end

    // stage 3 deltas, recomputed from the carried endpoints
    assign w_ux = segx_pkg::t_delta'(r_s3.aex) - segx_pkg::t_delta'(r_s3.ax);
    assign w_uy = segx_pkg::t_delta'(r_s3.aey) - segx_pkg::t_delta'(r_s3.ay);
    assign w_vx = segx_pkg::t_delta'(r_s3.bex) - segx_pkg::t_delta'(r_s3.bx);
    assign w_vy = segx_pkg::t_delta'(r_s3.bey) - segx_pkg::t_delta'(r_s3.by);
    assign w_wx = segx_pkg::t_delta'(r_s3.ax)  - segx_pkg::t_delta'(r_s3.bx);
    assign w_wy = segx_pkg::t_delta'(r_s3.ay)  - segx_pkg::t_delta'(r_s3.by);
    assign w_ex = segx_pkg::t_delta'(r_s3.aex) - segx_pkg::t_delta'(r_s3.bx);
    assign w_ey = segx_pkg::t_delta'(r_s3.aey) - segx_pkg::t_delta'(r_s3.by);

    assign w_d_neg  = r_s3_d[segx_pkg::CROSS_WIDTH-1];
    assign w_d_mag  = segx_pkg::t_mag'(w_d_neg ? -r_s3_d : r_s3_d);
    assign w_ns_mag = segx_pkg::t_mag'(r_s3_ns[segx_pkg::CROSS_WIDTH-1] ? -r_s3_ns : r_s3_ns);
    assign w_nt_mag = segx_pkg::t_mag'(r_s3_nt[segx_pkg::CROSS_WIDTH-1] ? -r_s3_nt : r_s3_nt);

    // zero determinant is parallel even with a zero threshold
    assign w_par = (r_s3_d == '0) || (w_d_mag < segx_pkg::t_mag'(i_thr));

    assign w_out_s = (r_s3_ns != '0 && (r_s3_ns[segx_pkg::CROSS_WIDTH-1] != w_d_neg))
                   || (w_ns_mag > w_d_mag);
    assign w_out_t = (r_s3_nt != '0 && (r_s3_nt[segx_pkg::CROSS_WIDTH-1] != w_d_neg))
                   || (w_nt_mag > w_d_mag);

    assign w_upt = (w_ux == '0) && (w_uy == '0);
    assign w_vpt = (w_vx == '0) && (w_vy == '0);

    assign w_on_b = (r_s3.bx != r_s3.bex) ? in_range(r_s3.ax, r_s3.bx, r_s3.bex)
                                          : in_range(r_s3.ay, r_s3.by, r_s3.bey);
    assign w_on_a = (r_s3.ax != r_s3.aex) ? in_range(r_s3.bx, r_s3.ax, r_s3.aex)
                                          : in_range(r_s3.by, r_s3.ay, r_s3.aey);

    // overlap parameter of B runs along x unless B is vertical
    assign w_n0 = (w_vx != '0) ? w_wx : w_wy;
    assign w_n1 = (w_vx != '0) ? w_ex : w_ey;
    assign w_dn = (w_vx != '0) ? w_vx : w_vy;
    assign w_n0_mag = delta_mag(w_n0);
    assign w_n1_mag = delta_mag(w_n1);
    assign w_dn_mag = delta_mag(w_dn);

    always_comb begin
        o_job = '0;
        o_job.side.mode = segx_pkg::MODE_DONE;
        o_job.side.kind = segx_pkg::KIND_NONE;
        if (w_par) begin
            if (r_s3_nt != '0 || r_s3_ns != '0) begin
                o_job.side.kind = segx_pkg::KIND_NONE;
            end else if (w_upt && w_vpt) begin
                if (r_s3.ax == r_s3.bx && r_s3.ay == r_s3.by) begin
                    o_job.side.kind   = segx_pkg::KIND_POINT;
                    o_job.side.base_x = r_s3.ax;
                    o_job.side.base_y = r_s3.ay;
                end
            end else if (w_upt) begin
                if (w_on_b) begin
                    o_job.side.kind   = segx_pkg::KIND_POINT;
                    o_job.side.base_x = r_s3.ax;
                    o_job.side.base_y = r_s3.ay;
                end
            end else if (w_vpt) begin
                if (w_on_a) begin
                    o_job.side.kind   = segx_pkg::KIND_POINT;
                    o_job.side.base_x = r_s3.bx;
                    o_job.side.base_y = r_s3.by;
                end
            end else begin
                o_job.side.mode    = segx_pkg::MODE_OVERLAP;
                o_job.side.base_x  = r_s3.bx;
                o_job.side.base_y  = r_s3.by;
                o_job.side.delta_x = w_vx;
                o_job.side.delta_y = w_vy;
                o_job.num0 = w_n0_mag;
                o_job.num1 = w_n1_mag;
                o_job.den  = w_dn_mag;
                o_job.neg0 = w_n0[segx_pkg::DELTA_WIDTH-1] != w_dn[segx_pkg::DELTA_WIDTH-1];
                o_job.neg1 = w_n1[segx_pkg::DELTA_WIDTH-1] != w_dn[segx_pkg::DELTA_WIDTH-1];
                o_job.sat0 = w_n0_mag > w_dn_mag;
                o_job.sat1 = w_n1_mag > w_dn_mag;
            end
        end else if (!w_out_s && !w_out_t) begin
            o_job.side.mode    = segx_pkg::MODE_CROSS;
            o_job.side.kind    = segx_pkg::KIND_POINT;
            o_job.side.base_x  = r_s3.ax;
            o_job.side.base_y  = r_s3.ay;
            o_job.side.delta_x = w_ux;
            o_job.side.delta_y = w_uy;
            o_job.num0 = w_ns_mag;
            o_job.den  = w_d_mag;
        end
    end

endmodule

/* hw/rtl/segx_queue.sv */
// Short job queue between front end and back end.
module segx_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  segx_pkg::t_job i_job,
    input  logic           i_pop,
    output segx_pkg::t_job o_job,
    output logic           o_valid,
    output logic           o_full
);

    segx_pkg::t_job                    r_mem [segx_pkg::QUEUE_DEPTH];
    logic [segx_pkg::QPTR_WIDTH-1:0]   r_wr_ptr, r_rd_ptr;
    logic [segx_pkg::QCNT_WIDTH-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + segx_pkg::QCNT_WIDTH'(i_push)
                               - segx_pkg::QCNT_WIDTH'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == segx_pkg::QCNT_WIDTH'(segx_pkg::QUEUE_DEPTH));

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= segx_pkg::QCNT_WIDTH'(segx_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");
`endif

endmodule

/* hw/rtl/segx_back.sv */
// Back end: divider lanes, clipping, point reconstruction, output register.
module segx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  segx_pkg::t_job   i_job,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_hit_kind,
    output segx_pkg::t_coord o_first_x,
    output segx_pkg::t_coord o_first_y,
    output segx_pkg::t_coord o_second_x,
    output segx_pkg::t_coord o_second_y
);

    typedef logic [segx_pkg::PARAM_FRAC:0]    t_tval;
    typedef logic [segx_pkg::COORD_WIDTH-1:0] t_umag;

    logic                w_en;
    logic                r_lv   [segx_pkg::PARAM_FRAC];
    segx_pkg::t_side     r_side [segx_pkg::PARAM_FRAC];
    segx_pkg::t_param    w_q0, w_q1, w_lo, w_hi;
    segx_pkg::t_side     w_side;
    logic                w_miss;
    t_tval               w_lo_c, w_hi_c;

    logic                r_p1_valid, r_p2_valid, r_out_valid;
    segx_pkg::t_kind     r_p1_kind, r_p2_kind, r_out_kind;
    t_tval               r_p1_t0, r_p1_t1;
    segx_pkg::t_coord    r_p1_bx, r_p1_by, r_p2_bx, r_p2_by;
    t_umag               r_p1_dmx, r_p1_dmy;
    logic                r_p1_dnx, r_p1_dny, r_p2_dnx, r_p2_dny;
    t_umag               r_p2_m0x, r_p2_m0y, r_p2_m1x, r_p2_m1y;
    segx_pkg::t_coord    r_out_fx, r_out_fy, r_out_sx, r_out_sy;
    segx_pkg::t_kind     w_kind;
    t_tval               w_t0, w_t1;
    logic [segx_pkg::PARAM_FRAC+segx_pkg::COORD_WIDTH:0] w_m0x, w_m0y, w_m1x, w_m1y;
    segx_pkg::t_delta    w_dx_abs, w_dy_abs;
    segx_pkg::t_coord    w_fx, w_fy, w_sx, w_sy;

    assign w_en      = !r_out_valid || !i_stall;
    assign o_job_pop = w_en && i_job_valid;

    segx_div u_div0 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (i_job.num0),
        .i_den  (i_job.den),
        .i_neg  (i_job.neg0),
        .i_sat  (i_job.sat0),
        .o_quot (w_q0)
    );

    segx_div u_div1 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (i_job.num1),
        .i_den  (i_job.den),
        .i_neg  (i_job.neg1),
        .i_sat  (i_job.sat1),
        .o_quot (w_q1)
    );

    // side data and valid follow the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < segx_pkg::PARAM_FRAC; k++) r_lv[k] <= 1'b0;
        end else if (w_en) begin
            r_lv[0] <= i_job_valid;
            for (int k = 1; k < segx_pkg::PARAM_FRAC; k++) r_lv[k] <= r_lv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= i_job.side;
            for (int k = 1; k < segx_pkg::PARAM_FRAC; k++) r_side[k] <= r_side[k-1];
        end
    end

    assign w_side = r_side[segx_pkg::PARAM_FRAC-1];

    // order, range test and clip of the overlap parameters
    assign w_lo   = (w_q0 > w_q1) ? w_q1 : w_q0;
    assign w_hi   = (w_q0 > w_q1) ? w_q0 : w_q1;
    assign w_miss = (w_lo > segx_pkg::PARAM_ONE) || (w_hi < 0);
    assign w_lo_c = (w_lo < 0) ? '0 : t_tval'(w_lo);
    assign w_hi_c = (w_hi > segx_pkg::PARAM_ONE) ? t_tval'(segx_pkg::PARAM_ONE) : t_tval'(w_hi);

    always_comb begin
        w_kind = w_side.kind;
        w_t0   = '0;
        w_t1   = '0;
        case (w_side.mode)
            segx_pkg::MODE_OVERLAP: begin
                w_t0 = w_lo_c;
                w_t1 = w_hi_c;
                if (w_miss)                w_kind = segx_pkg::KIND_NONE;
                else if (w_lo_c == w_hi_c) w_kind = segx_pkg::KIND_POINT;
                else                       w_kind = segx_pkg::KIND_SEGMENT;
            end
            segx_pkg::MODE_CROSS: begin
                w_kind = segx_pkg::KIND_POINT;
                w_t0   = t_tval'(w_q0);
            end
            default: begin
                w_kind = w_side.kind;
            end
        endcase
    end

    assign w_dx_abs = w_side.delta_x[segx_pkg::DELTA_WIDTH-1] ? -w_side.delta_x : w_side.delta_x;
    assign w_dy_abs = w_side.delta_y[segx_pkg::DELTA_WIDTH-1] ? -w_side.delta_y : w_side.delta_y;

    assign w_m0x = r_p1_t0 * r_p1_dmx;
    assign w_m0y = r_p1_t0 * r_p1_dmy;
    assign w_m1x = r_p1_t1 * r_p1_dmx;
    assign w_m1y = r_p1_t1 * r_p1_dmy;

    assign w_fx = r_p2_dnx ? r_p2_bx - r_p2_m0x : r_p2_bx + r_p2_m0x;
    assign w_fy = r_p2_dny ? r_p2_by - r_p2_m0y : r_p2_by + r_p2_m0y;
    assign w_sx = r_p2_dnx ? r_p2_bx - r_p2_m1x : r_p2_bx + r_p2_m1x;
    assign w_sy = r_p2_dny ? r_p2_by - r_p2_m1y : r_p2_by + r_p2_m1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid  <= r_lv[segx_pkg::PARAM_FRAC-1];
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_kind <= w_kind;
            r_p1_t0   <= w_t0;
            r_p1_t1   <= w_t1;
            r_p1_bx   <= w_side.base_x;
            r_p1_by   <= w_side.base_y;
            r_p1_dmx  <= t_umag'(w_dx_abs);
            r_p1_dmy  <= t_umag'(w_dy_abs);
            r_p1_dnx  <= w_side.delta_x[segx_pkg::DELTA_WIDTH-1];
            r_p1_dny  <= w_side.delta_y[segx_pkg::DELTA_WIDTH-1];

            r_p2_kind <= r_p1_kind;
            r_p2_bx   <= r_p1_bx;
            r_p2_by   <= r_p1_by;
            r_p2_dnx  <= r_p1_dnx;
            r_p2_dny  <= r_p1_dny;
            r_p2_m0x  <= w_m0x[segx_pkg::PARAM_FRAC+segx_pkg::COORD_WIDTH-1:segx_pkg::PARAM_FRAC];
            r_p2_m0y  <= w_m0y[segx_pkg::PARAM_FRAC+segx_pkg::COORD_WIDTH-1:segx_pkg::PARAM_FRAC];
            r_p2_m1x  <= w_m1x[segx_pkg::PARAM_FRAC+segx_pkg::COORD_WIDTH-1:segx_pkg::PARAM_FRAC];
            r_p2_m1y  <= w_m1y[segx_pkg::PARAM_FRAC+segx_pkg::COORD_WIDTH-1:segx_pkg::PARAM_FRAC];

            r_out_kind <= r_p2_kind;
            r_out_fx   <= (r_p2_kind == segx_pkg::KIND_NONE) ? '0 : w_fx;
            r_out_fy   <= (r_p2_kind == segx_pkg::KIND_NONE) ? '0 : w_fy;
            r_out_sx   <= (r_p2_kind == segx_pkg::KIND_SEGMENT) ? w_sx : '0;
            r_out_sy   <= (r_p2_kind == segx_pkg::KIND_SEGMENT) ? w_sy : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hit_kind = r_out_kind;
    assign o_first_x  = r_out_fx;
    assign o_first_y  = r_out_fy;
    assign o_second_x = r_out_sx;
    assign o_second_y = r_out_sy;

endmodule

/* hw/rtl/segment_intersection_2d_unit.sv */
// Top level of the 2D segment-segment intersection unit.
// Takes a pair of segments (signed Q12.12 endpoints) per request and returns
// one result per request: no contact, a single point, or a collinear overlap
// given by two points. Sustained rate is one request per clock while the
// output is not stalled. A request passes three front stages (input
// register, 25x25 products, cross determinants), the job queue, the
// bit-per-stage fraction divider, then a clip stage, a multiply stage and
// the output register. The front end keeps accepting while a result
// waits on a stalled output, until the four-entry job queue fills.
// parallel_threshold is written through the configuration channel (always
// ready); it must only change while no request is in flight.
module segment_intersection_2d_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [23:0]              i_a_start_x,
    input  logic signed [23:0]              i_a_start_y,
    input  logic signed [23:0]              i_a_end_x,
    input  logic signed [23:0]              i_a_end_y,
    input  logic signed [23:0]              i_b_start_x,
    input  logic signed [23:0]              i_b_start_y,
    input  logic signed [23:0]              i_b_end_x,
    input  logic signed [23:0]              i_b_end_y,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_hit_kind,
    output logic signed [23:0]              o_first_x,
    output logic signed [23:0]              o_first_y,
    output logic signed [23:0]              o_second_x,
    output logic signed [23:0]              o_second_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [39:0]                     i_cfg_data
);

    logic [segx_pkg::THR_WIDTH-1:0] r_thr;
    segx_pkg::t_job                 w_push_job, w_head_job;
    logic                           w_push, w_pop, w_head_valid, w_full;

    // config register: threshold on |determinant| for the parallel path
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= segx_pkg::THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // front: products, determinant and case split
    segx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .i_thr       (r_thr),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // decouples front stalls from output back-pressure
    segx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_valid (w_head_valid),
        .o_full  (w_full)
    );

    // back: divide, clip, rebuild points
    segx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_job_valid (w_head_valid),
        .o_job_pop   (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_hit_kind  (o_hit_kind),
        .o_first_x   (o_first_x),
        .o_first_y   (o_first_y),
        .o_second_x  (o_second_x),
        .o_second_y  (o_second_y)
    );

`ifndef ASSERT_OFF
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_kind == segx_pkg::KIND_NONE) |->
        (o_first_x == '0 && o_first_y == '0 && o_second_x == '0 && o_second_y == '0))
        else $error("no-contact result carries nonzero points");
    a_point_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_kind == segx_pkg::KIND_POINT) |->
        (o_second_x == '0 && o_second_y == '0))
        else $error("single-point result carries a second point");
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit_kind <= segx_pkg::KIND_SEGMENT))
        else $error("illegal hit kind");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_hit_kind) && $stable(o_first_x) &&
         $stable(o_first_y) && $stable(o_second_x) && $stable(o_second_y)))
        else $error("stalled result changed");
`endif

endmodule
